>>> src/swm_pkg.sv
// Package for the star wildcard matcher: sizes, action codes, star byte,
// and the control struct that the top level drives into each pattern cell.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int PAT_MAX = 32;
    localparam int LEN_W   = $clog2(PAT_MAX + 1);
    localparam int ACT_W   = PAT_MAX + 1;

    localparam logic [7:0] STAR_CODE = 8'd42;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    typedef struct packed {
        logic load;
        logic in_range;
        logic step;
        logic restart;
    } t_cell_ctrl;

endpackage

>>> src/swm_cell.sv
// One pattern cell: holds one pattern byte and the raw active bit of its
// position, and hands a literal match on to the next cell.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_seed,
    input  logic [7:0] i_code,
    input  logic       i_closed,
    input  logic       i_fwd,
    output logic       o_star,
    output logic       o_raw,
    output logic       o_fwd
);

    logic [7:0] r_byte;
    logic       r_raw;
    logic       n_raw;
    logic       w_is_star;
    logic       w_stay;

    assign w_is_star = (r_byte == STAR_CODE);
    assign o_star    = i_ctrl.in_range & w_is_star;
    assign w_stay    = i_closed & o_star;
    assign o_fwd     = i_closed & i_ctrl.in_range & ~w_is_star & (r_byte == i_code);
    assign o_raw     = r_raw;

    always_comb begin
        n_raw = r_raw;
        if (i_ctrl.restart) begin
            n_raw = i_seed;
        end else if (i_ctrl.step) begin
            n_raw = w_stay | i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_byte <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= i_seed;
        end else begin
            r_raw <= n_raw;
        end
    end

endmodule

>>> src/swm_out_buf.sv
// Result buffer: output register plus one skid entry, so the input side
// keeps moving while one result waits; o_full flags a full skid entry.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_out_buf
    import swm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_matched,
    input  logic i_too_long,
    input  logic i_out_ready,
    output logic o_out_valid,
    output logic o_matched,
    output logic o_too_long,
    output logic o_full
);

    logic r_out_valid;
    logic r_skid_valid;
    logic r_out_matched;
    logic r_out_too_long;
    logic r_skid_matched;
    logic r_skid_too_long;
    logic w_pop;

    assign w_pop       = r_out_valid & i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;
    assign o_too_long  = r_out_too_long;
    assign o_full      = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_matched  <= r_skid_matched;
                r_out_too_long <= r_skid_too_long;
            end else begin
                r_out_matched  <= i_matched;
                r_out_too_long <= i_too_long;
            end
        end else if (i_push) begin
            r_skid_matched  <= i_matched;
            r_skid_too_long <= i_too_long;
        end
    end

endmodule

>>> src/star_wildcard_matcher.sv
// Star wildcard matcher top level: a row of pattern cells, star closure
// by one carry chain, pattern length and overflow control, result buffer.
// End-of-text registers its result in the result buffer; one transaction
// is taken per cycle unless that buffer is full; cells update per text byte.
// Reset (synchronous, active low) clears length, overflow and result buffer
// and activates position 0 only; pattern bytes are kept until rewritten.
`timescale 1ns / 1ps

module star_wildcard_matcher
    import swm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_too_long
);

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic               r_ovf;
    logic               n_ovf;
    logic               r_raw_end;
    logic               n_raw_end;
    logic               w_accept;
    logic               w_full_buf;
    logic               w_store_full;
    logic               w_step;
    logic               w_restart;
    logic               w_load;
    logic               w_push;
    t_action            w_action;
    logic [PAT_MAX-1:0] w_star;
    logic [PAT_MAX-1:0] w_raw_cell;
    logic [PAT_MAX-1:0] w_fwd;
    logic [ACT_W-1:0]   w_raw;
    logic [ACT_W-1:0]   w_prop;
    logic [ACT_W-1:0]   w_gen;
    logic [ACT_W-1:0]   w_sum;
    logic [ACT_W-1:0]   w_carry;
    logic [ACT_W-1:0]   w_closed;

    assign w_action     = t_action'(i_action);
    assign o_in_ready   = ~w_full_buf;
    assign w_accept     = i_in_valid & o_in_ready;
    assign w_store_full = (r_len == LEN_W'(PAT_MAX));

    always_comb begin
        n_len     = r_len;
        n_ovf     = r_ovf;
        w_step    = 1'b0;
        w_restart = 1'b0;
        w_load    = 1'b0;
        w_push    = 1'b0;
        if (w_accept) begin
            unique case (w_action)
                ACT_CLEAR: begin
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    w_restart = 1'b1;
                end
                ACT_APPEND: begin
                    if (w_store_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_load = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                    end
                    w_restart = 1'b1;
                end
                ACT_TEXT: begin
                    w_step = 1'b1;
                end
                ACT_END: begin
                    w_push    = 1'b1;
                    w_restart = 1'b1;
                end
                default: begin
                    w_step = 1'b0;
                end
            endcase
        end
    end

    // close raw active set over runs of stars as a carry chain
    assign w_raw   = {r_raw_end, w_raw_cell};
    assign w_prop  = {1'b0, w_star};
    assign w_gen   = w_prop & w_raw;
    assign w_sum   = w_prop + w_gen;
    assign w_carry = w_sum ^ w_prop ^ w_gen;
    assign w_closed = w_raw | w_carry;

    for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        logic       w_fwd_in;

        assign w_ctrl.load     = w_load & (r_len == LEN_W'(g));
        assign w_ctrl.in_range = (LEN_W'(g) < r_len);
        assign w_ctrl.step     = w_step;
        assign w_ctrl.restart  = w_restart;

        if (g == 0) begin : g_first
            assign w_fwd_in = 1'b0;
        end else begin : g_rest
            assign w_fwd_in = w_fwd[g-1];
        end

        swm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_seed   ((g == 0) ? 1'b1 : 1'b0),
            .i_code   (i_char_code),
            .i_closed (w_closed[g]),
            .i_fwd    (w_fwd_in),
            .o_star   (w_star[g]),
            .o_raw    (w_raw_cell[g]),
            .o_fwd    (w_fwd[g])
        );
    end

    always_comb begin
        n_raw_end = r_raw_end;
        if (w_restart) begin
            n_raw_end = 1'b0;
        end else if (w_step) begin
            n_raw_end = w_fwd[PAT_MAX-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_raw_end <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_raw_end <= n_raw_end;
        end
    end

    swm_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_matched   (~r_ovf & w_closed[r_len]),
        .i_too_long  (r_ovf),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_matched   (o_matched),
        .o_too_long  (o_too_long),
        .o_full      (w_full_buf)
    );

endmodule

>>> src/swm_checker.sv
// Port-level checker for the star wildcard matcher, bound to the top level.
// Depends on swm_pkg and star_wildcard_matcher.
`timescale 1ns / 1ps

module swm_checker
    import swm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_action,
    input logic [7:0] i_char_code,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_matched,
    input logic       o_too_long
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == ACT_END && !o_out_valid |=> o_out_valid)
        else $error("end transaction gave no result");

    a_overflow_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_matched && o_too_long))
        else $error("match reported with overflowed pattern");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_matched) && $stable(o_too_long))
        else $error("result changed while stalled");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (.*);
